@@ rtl/pswb_pkg.sv @@
// Shared types and codes for the per-address sliding-window ban table.
`default_nettype none
package pswb_pkg;

	typedef enum logic [1:0] {
		CMD_RECORD = 2'd0,
		CMD_QUERY  = 2'd1,
		CMD_SWEEP  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [0:0] {
		REG_WINDOW    = 1'b0,
		REG_THRESHOLD = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_PRUNE,
		ST_PRUNE_CHK,
		ST_APPEND,
		ST_QSCAN,
		ST_QCHK,
		ST_SW_SEL,
		ST_SW_END,
		ST_RESULT
	} state_t;

	localparam logic [31:0] WINDOW_RESET    = 32'd60;
	localparam logic [4:0]  THRESHOLD_RESET = 5'd5;

endpackage
`default_nettype wire

@@ rtl/pswb_cell.sv @@
// One table entry: valid, address, ring head and fill, plus its link in the select chain.
`default_nettype none
module pswb_cell #(
	parameter int IDX_W  = 6,
	parameter int FILL_W = 5,
	parameter int SLOT_W = 4,
	parameter logic [IDX_W-1:0] MY_IDX = '0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              by_index,
	input  wire logic [IDX_W-1:0]  sel_idx,
	input  wire logic [63:0]       key_high,
	input  wire logic [63:0]       key_low,
	input  wire logic              wr_en,
	input  wire logic [IDX_W-1:0]  wr_idx,
	input  wire logic              wr_valid,
	input  wire logic              wr_addr_en,
	input  wire logic [SLOT_W-1:0] wr_head,
	input  wire logic [FILL_W-1:0] wr_fill,
	input  wire logic              hit_i,
	input  wire logic [IDX_W-1:0]  idx_i,
	input  wire logic              valid_i,
	input  wire logic [SLOT_W-1:0] head_i,
	input  wire logic [FILL_W-1:0] fill_i,
	input  wire logic              free_i,
	input  wire logic [IDX_W-1:0]  fidx_i,
	output logic                   hit_o,
	output logic [IDX_W-1:0]       idx_o,
	output logic                   valid_o,
	output logic [SLOT_W-1:0]      head_o,
	output logic [FILL_W-1:0]      fill_o,
	output logic                   free_o,
	output logic [IDX_W-1:0]       fidx_o
);
	logic              valid_q;
	logic [SLOT_W-1:0] head_q;
	logic [FILL_W-1:0] fill_q;
	logic [63:0]       addr_high_q;
	logic [63:0]       addr_low_q;
	logic              sel;
	logic              wr_me;

	assign wr_me = wr_en && (wr_idx == MY_IDX);
	assign sel = by_index ? (sel_idx == MY_IDX) :
		(valid_q && addr_high_q == key_high && addr_low_q == key_low);

	always_comb begin
		hit_o   = hit_i | sel;
		idx_o   = sel ? MY_IDX : idx_i;
		valid_o = sel ? valid_q : valid_i;
		head_o  = sel ? head_q : head_i;
		fill_o  = sel ? fill_q : fill_i;
		free_o  = free_i | !valid_q;
		fidx_o  = (!free_i && !valid_q) ? MY_IDX : fidx_i;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			head_q  <= '0;
			fill_q  <= '0;
		end else if (wr_me) begin
			valid_q <= wr_valid;
			head_q  <= wr_head;
			fill_q  <= wr_fill;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_me && wr_addr_en) begin
			addr_high_q <= key_high;
			addr_low_q  <= key_low;
		end
	end

endmodule
`default_nettype wire

@@ rtl/per_address_sliding_window_ban_table_top.sv @@
// Per-address sliding-window ban table: entry cell chain, stamp memory and command sequencer.
//
// Channels: input requests (command, address, now_ticks) on in_valid/in_ready,
// one result per request on out_valid/out_ready, register writes on
// cfg_valid/cfg_ready (index 0 window_ticks, 1 ban_threshold; always ready).
// One request is worked at a time; in_ready is high only while idle.
// Paths: a record on a full table goes straight to the result; a record for
// a new address appends in a free entry; a record for a known address prunes
// aged stamps from the ring head, then appends. A query of an unknown address
// and an unused command go straight to the result; a known query counts stamps
// from the newest until one is aged or all are counted. A sweep prunes each used
// entry, freeing it when its ring empties. Stamp reads use one port, registered data.
// A new request is taken the cycle after the result is loaded into
// the output register, even if the receiver has not yet taken it.
// The output register holds its result while out_ready is low; the
// sequencer then waits before loading the next result.
// Reset clears all entry valid bits, ring heads and fills and loads
// window 60 and threshold 5; stamps and addresses need no clearing.
`default_nettype none
module per_address_sliding_window_ban_table_top #(
	parameter int ENTRIES   = 64,
	parameter int DEPTH     = 16,
	parameter int TIME_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  command,
	input  wire logic [63:0] address_high,
	input  wire logic [63:0] address_low,
	input  wire logic [31:0] now_ticks,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [4:0]       offense_count,
	output logic             over_threshold,
	output logic             address_found,
	output logic             table_full,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	import pswb_pkg::*;

	localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int SLOT_W = $clog2(DEPTH);
	localparam int FILL_W = $clog2(DEPTH + 1);
	localparam int SUM_W  = FILL_W + 1;
	localparam int MEM_AW = IDX_W + SLOT_W;
	localparam int AW     = (TIME_BITS > 32) ? TIME_BITS : 32;
	localparam int CW     = (FILL_W > 5) ? FILL_W : 5;

	state_t state_q, state_d;

	logic [31:0]          window_q;
	logic [4:0]           thr_q;
	logic                 out_valid_q;
	logic [4:0]           out_count_q;
	logic                 out_over_q;
	logic                 out_found_q;
	logic                 out_full_q;

	cmd_t                 cmd_q;
	logic [63:0]          key_high_q;
	logic [63:0]          key_low_q;
	logic [TIME_BITS-1:0] now_q;
	logic [IDX_W-1:0]     cur_idx_q;
	logic [SLOT_W-1:0]    cur_head_q;
	logic [FILL_W-1:0]    cur_fill_q;
	logic [FILL_W-1:0]    n_q;
	logic [IDX_W-1:0]     sweep_idx_q;
	logic [FILL_W-1:0]    res_count_q;
	logic                 res_found_q;
	logic                 res_full_q;

	logic [TIME_BITS-1:0] mem [ENTRIES << SLOT_W];
	logic [TIME_BITS-1:0] mem_rd_q;
	logic [MEM_AW-1:0]    rd_addr;
	logic                 mem_we;
	logic [MEM_AW-1:0]    wr_addr;

	logic                 c_hit   [ENTRIES+1];
	logic [IDX_W-1:0]     c_idx   [ENTRIES+1];
	logic                 c_valid [ENTRIES+1];
	logic [SLOT_W-1:0]    c_head  [ENTRIES+1];
	logic [FILL_W-1:0]    c_fill  [ENTRIES+1];
	logic                 c_free  [ENTRIES+1];
	logic [IDX_W-1:0]     c_fidx  [ENTRIES+1];

	logic                 by_index;
	logic                 wr_en;
	logic                 wr_valid;
	logic                 wr_addr_en;
	logic [SLOT_W-1:0]    wr_head;
	logic [FILL_W-1:0]    wr_fill;

	logic                 is_sweep;
	logic                 last_entry;
	logic                 stamp_aged;
	logic [TIME_BITS-1:0] age;
	logic [SLOT_W-1:0]    head_inc;
	logic [SUM_W-1:0]     app_sum;
	logic [SUM_W-1:0]     q_sum;
	logic [SLOT_W-1:0]    app_slot;
	logic [SLOT_W-1:0]    q_slot;
	logic                 ring_full;
	logic [SLOT_W-1:0]    new_head;
	logic [FILL_W-1:0]    new_fill;
	logic                 load_out;
	logic                 accept;

	function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SUM_W-1:0] v);
		logic [SUM_W-1:0] r;
		r = (v >= SUM_W'(DEPTH)) ? v - SUM_W'(DEPTH) : v;
		return r[SLOT_W-1:0];
	endfunction

	assign is_sweep   = (cmd_q == CMD_SWEEP);
	assign by_index   = is_sweep;
	assign last_entry = (sweep_idx_q == IDX_W'(ENTRIES - 1));
	assign accept     = in_valid && in_ready;
	assign cfg_ready  = 1'b1;

	assign age        = now_q - mem_rd_q;
	assign stamp_aged = !(AW'(age) < AW'(window_q));

	assign head_inc  = (cur_head_q == SLOT_W'(DEPTH - 1)) ? '0 : cur_head_q + 1'b1;
	assign app_sum   = SUM_W'(cur_head_q) + SUM_W'(cur_fill_q);
	assign q_sum     = SUM_W'(cur_head_q) + SUM_W'(cur_fill_q) - SUM_W'(1) - SUM_W'(n_q);
	assign app_slot  = wrap_slot(app_sum);
	assign q_slot    = wrap_slot(q_sum);
	assign ring_full = (cur_fill_q >= FILL_W'(DEPTH));
	assign new_head  = ring_full ? head_inc : cur_head_q;
	assign new_fill  = ring_full ? FILL_W'(DEPTH) : cur_fill_q + 1'b1;

	// Select chain: address match or index select, first free entry.
	assign c_hit[0]   = 1'b0;
	assign c_idx[0]   = '0;
	assign c_valid[0] = 1'b0;
	assign c_head[0]  = '0;
	assign c_fill[0]  = '0;
	assign c_free[0]  = 1'b0;
	assign c_fidx[0]  = '0;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		pswb_cell #(
			.IDX_W (IDX_W),
			.FILL_W(FILL_W),
			.SLOT_W(SLOT_W),
			.MY_IDX(IDX_W'(g))
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.by_index  (by_index),
			.sel_idx   (sweep_idx_q),
			.key_high  (key_high_q),
			.key_low   (key_low_q),
			.wr_en     (wr_en),
			.wr_idx    (cur_idx_q),
			.wr_valid  (wr_valid),
			.wr_addr_en(wr_addr_en),
			.wr_head   (wr_head),
			.wr_fill   (wr_fill),
			.hit_i     (c_hit[g]),
			.idx_i     (c_idx[g]),
			.valid_i   (c_valid[g]),
			.head_i    (c_head[g]),
			.fill_i    (c_fill[g]),
			.free_i    (c_free[g]),
			.fidx_i    (c_fidx[g]),
			.hit_o     (c_hit[g+1]),
			.idx_o     (c_idx[g+1]),
			.valid_o   (c_valid[g+1]),
			.head_o    (c_head[g+1]),
			.fill_o    (c_fill[g+1]),
			.free_o    (c_free[g+1]),
			.fidx_o    (c_fidx[g+1])
		);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				case (cmd_q)
					CMD_RECORD: begin
						if (c_hit[ENTRIES]) state_d = ST_PRUNE;
						else if (c_free[ENTRIES]) state_d = ST_APPEND;
						else state_d = ST_RESULT;
					end
					CMD_QUERY: state_d = c_hit[ENTRIES] ? ST_QSCAN : ST_RESULT;
					CMD_SWEEP: state_d = ST_SW_SEL;
					default:   state_d = ST_RESULT;
				endcase
			end
			ST_PRUNE: begin
				if (cur_fill_q == '0) state_d = is_sweep ? ST_SW_END : ST_APPEND;
				else state_d = ST_PRUNE_CHK;
			end
			ST_PRUNE_CHK: begin
				if (stamp_aged) state_d = ST_PRUNE;
				else state_d = is_sweep ? ST_SW_END : ST_APPEND;
			end
			ST_APPEND: state_d = ST_RESULT;
			ST_QSCAN: state_d = (n_q == cur_fill_q) ? ST_RESULT : ST_QCHK;
			ST_QCHK: state_d = stamp_aged ? ST_RESULT : ST_QSCAN;
			ST_SW_SEL: begin
				if (c_valid[ENTRIES]) state_d = ST_PRUNE;
				else if (last_entry) state_d = ST_RESULT;
			end
			ST_SW_END: state_d = last_entry ? ST_RESULT : ST_SW_SEL;
			ST_RESULT: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs and strobes
	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		load_out   = (state_q == ST_RESULT) && (!out_valid_q || out_ready);
		wr_en      = 1'b0;
		wr_valid   = 1'b0;
		wr_addr_en = 1'b0;
		wr_head    = cur_head_q;
		wr_fill    = cur_fill_q;
		mem_we     = 1'b0;
		wr_addr    = {cur_idx_q, ring_full ? cur_head_q : app_slot};
		rd_addr    = {cur_idx_q, cur_head_q};
		case (state_q)
			ST_APPEND: begin
				wr_en      = 1'b1;
				wr_valid   = 1'b1;
				wr_addr_en = 1'b1;
				wr_head    = new_head;
				wr_fill    = new_fill;
				mem_we     = 1'b1;
			end
			ST_SW_END: begin
				wr_en    = 1'b1;
				wr_valid = (cur_fill_q != '0);
				wr_head  = (cur_fill_q == '0) ? '0 : cur_head_q;
			end
			ST_QSCAN: rd_addr = {cur_idx_q, q_slot};
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			window_q    <= WINDOW_RESET;
			thr_q       <= THRESHOLD_RESET;
		end else begin
			state_q <= state_d;
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_WINDOW:    window_q <= cfg_data;
					REG_THRESHOLD: thr_q    <= cfg_data[4:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		mem_rd_q <= mem[rd_addr];
		if (mem_we) mem[wr_addr] <= now_q;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_count_q <= CW'(res_count_q) > CW'(0) ? 5'(CW'(res_count_q)) : '0;
			out_over_q  <= CW'(res_count_q) > CW'(thr_q);
			out_found_q <= res_found_q;
			out_full_q  <= res_full_q;
		end
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_q       <= cmd_t'(command);
					key_high_q  <= address_high;
					key_low_q   <= address_low;
					now_q       <= TIME_BITS'(now_ticks);
					res_count_q <= '0;
					res_found_q <= 1'b0;
					res_full_q  <= 1'b0;
					sweep_idx_q <= '0;
				end
			end
			ST_LOOKUP: begin
				cur_idx_q   <= c_hit[ENTRIES] ? c_idx[ENTRIES] : c_fidx[ENTRIES];
				cur_head_q  <= c_hit[ENTRIES] ? c_head[ENTRIES] : '0;
				cur_fill_q  <= c_hit[ENTRIES] ? c_fill[ENTRIES] : '0;
				n_q         <= '0;
				res_found_q <= c_hit[ENTRIES] && (cmd_q == CMD_RECORD || cmd_q == CMD_QUERY);
				res_full_q  <= (cmd_q == CMD_RECORD) && !c_hit[ENTRIES] && !c_free[ENTRIES];
			end
			ST_PRUNE_CHK: begin
				if (stamp_aged) begin
					cur_head_q <= head_inc;
					cur_fill_q <= cur_fill_q - 1'b1;
				end
			end
			ST_APPEND: res_count_q <= new_fill;
			ST_QSCAN: begin
				if (n_q == cur_fill_q) res_count_q <= n_q;
			end
			ST_QCHK: begin
				if (stamp_aged) res_count_q <= n_q;
				else n_q <= n_q + 1'b1;
			end
			ST_SW_SEL: begin
				cur_idx_q  <= sweep_idx_q;
				cur_head_q <= c_head[ENTRIES];
				cur_fill_q <= c_fill[ENTRIES];
				if (!c_valid[ENTRIES] && !last_entry) sweep_idx_q <= sweep_idx_q + 1'b1;
			end
			ST_SW_END: begin
				if (!last_entry) sweep_idx_q <= sweep_idx_q + 1'b1;
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign offense_count  = out_count_q;
	assign over_threshold = out_over_q;
	assign address_found  = out_found_q;
	assign table_full     = out_full_q;

endmodule
`default_nettype wire

@@ rtl/pswb_checker.sv @@
// Port-level checks for the ban table, bound to the top level.
`default_nettype none
module pswb_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [4:0] offense_count,
	input wire logic       over_threshold,
	input wire logic       address_found,
	input wire logic       table_full
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(offense_count))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while another is in work");

	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_full |-> offense_count == 5'd0 && !address_found)
		else $error("full table result carries a count");

	a_over_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && over_threshold |-> offense_count != 5'd0)
		else $error("over threshold with zero count");

endmodule

bind per_address_sliding_window_ban_table_top pswb_checker u_pswb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.offense_count (offense_count),
	.over_threshold(over_threshold),
	.address_found (address_found),
	.table_full    (table_full)
);
`default_nettype wire

@@ test/per_address_sliding_window_ban_table_top_tb.sv @@
// Testbench for the per-address sliding-window ban table: random and directed requests checked against a predictor.
`default_nettype none
module per_address_sliding_window_ban_table_top_tb;
	import pswb_pkg::*;

	localparam int SLOTS = 64;
	localparam int RING = 16;

	class ban_scoreboard;
		bit        slot_used[SLOTS];
		bit [63:0] slot_hi[SLOTS];
		bit [63:0] slot_lo[SLOTS];
		bit [31:0] stamps[SLOTS][RING];
		int        head[SLOTS];
		int        fill[SLOTS];
		bit [31:0] window;
		bit [4:0]  threshold;
		bit [7:0]  pending[$];
		int        errors;
		int        results;
		int        full_hits;
		int        over_hits;

		function void clear();
			foreach (slot_used[i]) begin
				slot_used[i] = 0;
				head[i] = 0;
				fill[i] = 0;
			end
			window = WINDOW_RESET;
			threshold = THRESHOLD_RESET;
		endfunction

		function bit is_aged(bit [31:0] st, bit [31:0] now);
			bit [31:0] age;
			age = now - st;
			return !(age < window);
		endfunction

		function void trim(int e, bit [31:0] now);
			while (fill[e] > 0 && is_aged(stamps[e][head[e]], now)) begin
				head[e] = (head[e] + 1) % RING;
				fill[e]--;
			end
		endfunction

		function int find(bit [63:0] hi, bit [63:0] lo);
			for (int e = 0; e < SLOTS; e++)
				if (slot_used[e] && slot_hi[e] == hi && slot_lo[e] == lo)
					return e;
			return -1;
		endfunction

		// packs {count, over, found, full}
		function void note_request(cmd_t cmd, bit [63:0] hi, bit [63:0] lo, bit [31:0] now);
			int        e;
			int        n;
			bit [4:0]  cnt;
			bit        ov, fnd, ful;
			cnt = 0; ov = 0; fnd = 0; ful = 0;
			if (cmd == CMD_RECORD) begin
				e = find(hi, lo);
				if (e >= 0) begin
					fnd = 1;
				end else begin
					for (int i = 0; i < SLOTS; i++)
						if (!slot_used[i] && e < 0)
							e = i;
					if (e >= 0) begin
						slot_used[e] = 1;
						slot_hi[e] = hi;
						slot_lo[e] = lo;
						head[e] = 0;
						fill[e] = 0;
					end else begin
						ful = 1;
					end
				end
				if (e >= 0) begin
					trim(e, now);
					if (fill[e] >= RING) begin
						stamps[e][head[e]] = now;
						head[e] = (head[e] + 1) % RING;
					end else begin
						stamps[e][(head[e] + fill[e]) % RING] = now;
						fill[e]++;
					end
					cnt = 5'(fill[e]);
					ov = cnt > threshold;
				end
			end else if (cmd == CMD_QUERY) begin
				e = find(hi, lo);
				if (e >= 0) begin
					fnd = 1;
					n = 0;
					while (n < fill[e] &&
						!is_aged(stamps[e][(head[e] + fill[e] - 1 - n) % RING], now))
						n++;
					cnt = 5'(n);
					ov = cnt > threshold;
				end
			end else if (cmd == CMD_SWEEP) begin
				for (int i = 0; i < SLOTS; i++) begin
					if (slot_used[i]) begin
						trim(i, now);
						if (fill[i] == 0) begin
							slot_used[i] = 0;
							head[i] = 0;
						end
					end
				end
			end
			full_hits += ful;
			over_hits += ov;
			pending.insert(pending.size(), {cnt, ov, fnd, ful});
		endfunction

		function void check_result(bit [4:0] cnt, bit ov, bit fnd, bit ful);
			bit [7:0] exp;
			results++;
			if (pending.size() == 0) begin
				$display("%0t: result with none expected: count %0d over %0d found %0d full %0d",
					$time, cnt, ov, fnd, ful);
				errors++;
				return;
			end
			exp = pending[0];
			pending.delete(0);
			if (exp[7:3] != cnt) begin
				$display("%0t: offense_count expected %0d actual %0d", $time, exp[7:3], cnt);
				errors++;
			end
			if (exp[2] != ov) begin
				$display("%0t: over_threshold expected %0d actual %0d", $time, exp[2], ov);
				errors++;
			end
			if (exp[1] != fnd) begin
				$display("%0t: address_found expected %0d actual %0d", $time, exp[1], fnd);
				errors++;
			end
			if (exp[0] != ful) begin
				$display("%0t: table_full expected %0d actual %0d", $time, exp[0], ful);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [1:0]  command = CMD_NONE;
	logic [63:0] address_high = 0;
	logic [63:0] address_low = 0;
	logic [31:0] now_ticks = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [4:0]  offense_count;
	logic        over_threshold;
	logic        address_found;
	logic        table_full;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [0:0]  cfg_index = REG_WINDOW;
	logic [31:0] cfg_data = 0;

	ban_scoreboard sb = new();
	bit [63:0] pool_hi[12];
	bit [63:0] pool_lo[12];
	bit [31:0] tick;
	bit        steady_ready;
	int        sent;

	per_address_sliding_window_ban_table_top dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (in_valid && in_ready)
			sb.note_request(cmd_t'(command), address_high, address_low, now_ticks);
		if (out_valid && out_ready)
			sb.check_result(offense_count, over_threshold, address_found, table_full);
	end

	int stall_left = 0;
	always @(posedge clk) begin
		if (steady_ready) begin
			out_ready <= 1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= ($urandom_range(0, 2) != 0);
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
				: $urandom_range(0, 3);
		end
	end

	function int pick_gap();
		if (steady_ready)
			return 0;
		return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
	endfunction

	task send(cmd_t c, bit [63:0] hi, bit [63:0] lo, bit [31:0] now);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		command <= c;
		address_high <= hi;
		address_low <= lo;
		now_ticks <= now;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	// leaves cfg_valid high; the caller drops it once its writes are done
	task write_reg(reg_idx_t idx, bit [31:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.window = (idx == REG_WINDOW) ? val : sb.window;
		sb.threshold = (idx == REG_THRESHOLD) ? val[4:0] : sb.threshold;
	endtask

	task drain();
		in_valid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// mode 0 mixed, 1 hot bursts, 2 flood of new addresses
	task run_phase(bit [31:0] win, bit [4:0] thr, int n, int mode, bit [31:0] step);
		int        r;
		int        k;
		bit [63:0] hi, lo;
		cmd_t      c;
		write_reg(REG_WINDOW, win);
		write_reg(REG_THRESHOLD, thr);
		cfg_valid <= 0;
		steady_ready = ($urandom_range(0, 2) == 0);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			k = (mode == 1) ? $urandom_range(0, 2) : $urandom_range(0, 11);
			hi = pool_hi[k];
			lo = pool_lo[k];
			if (r < 3)
				tick = tick - $urandom_range(1, 100);
			else if (mode != 1 || r < 20)
				tick = tick + $urandom_range(0, step);
			if (mode == 2 && r < 70) begin
				c = CMD_RECORD;
				hi = {$urandom, $urandom};
				lo = {$urandom, $urandom};
			end else if (r < 55) begin
				c = CMD_RECORD;
			end else if (r < 85) begin
				c = CMD_QUERY;
			end else if (r < 90) begin
				c = CMD_QUERY;
				lo = {$urandom, $urandom};
			end else if (r < 95) begin
				c = (mode == 2) ? CMD_QUERY : CMD_SWEEP;
			end else begin
				c = CMD_NONE;
			end
			send(c, hi, lo, tick);
		end
		drain();
	endtask

	initial begin
		#150_000_000;
		$display("per_address_sliding_window_ban_table_top_tb: errors");
		$finish;
	end

	initial begin
		sb.clear();
		foreach (pool_hi[i]) begin
			pool_hi[i] = (i % 3 == 0) ? 64'd0 : {$urandom, $urandom};
			pool_lo[i] = (i % 3 == 0) ? {32'd0, $urandom} : {$urandom, $urandom};
		end
		pool_hi[1] = '1;
		pool_lo[1] = '1;
		pool_hi[2] = 0;
		pool_lo[2] = 0;
		steady_ready = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset settings, extremes, every command
		send(CMD_QUERY, 64'd0, 64'd0, 32'd0);
		send(CMD_RECORD, 64'd0, 64'd0, 32'd0);
		send(CMD_RECORD, '1, '1, 32'd10);
		send(CMD_RECORD, 64'd0, 64'd0, 32'd20);
		send(CMD_QUERY, 64'd0, 64'd0, 32'd30);
		send(CMD_QUERY, '1, '1, 32'd75);
		send(CMD_NONE, '1, '1, 32'd80);
		send(CMD_SWEEP, 64'hA5A5A5A5A5A5A5A5, 64'h5A5A5A5A5A5A5A5A, 32'd80);
		send(CMD_QUERY, 64'd0, 64'd0, 32'd80);
		for (int i = 0; i < 8; i++)
			send(CMD_RECORD, '1, '1, 32'd90 + i);
		send(CMD_QUERY, '1, '1, 32'd100);
		send(CMD_RECORD, '1, '1, 32'hFFFFFFFF);
		send(CMD_SWEEP, 64'd0, 64'd0, 32'hFFFFFFFF);
		send(CMD_RECORD, 64'hFFFFFFFF00000000, 64'h00000000FFFFFFFF, 32'd5);
		drain();

		tick = 32'd1000;
		run_phase(32'd60, 5'd5, 200, 0, 20);
		run_phase(32'hFFFFFFFF, 5'd16, 150, 1, 3);
		run_phase(32'd0, 5'd0, 80, 0, 5);
		run_phase(32'd100000, 5'd31, 150, 2, 2);
		tick = 32'hFFFFFF00;
		run_phase(32'd1, 5'd3, 150, 1, 2);
		run_phase($urandom_range(2, 500), 5'($urandom_range(0, 16)), 300, 0, 40);

		$display("%0d requests sent, %0d results checked (%0d full-table, %0d over threshold)",
			sent, sb.results, sb.full_hits, sb.over_hits);
		$display("covered window 0..max, thresholds 0..31, ring overflow, time wrap");
		if (sb.errors == 0)
			$display("per_address_sliding_window_ban_table_top_tb: clean");
		else
			$display("per_address_sliding_window_ban_table_top_tb: errors");
		$finish;
	end
endmodule
`default_nettype wire
